// ===== rtl/core/bstack_pkg.sv =====
`timescale 1ns / 1ps

package bstack_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W   = 2;
	localparam int POS_W  = 9;
	localparam int CAP_W  = 9;
	localparam int ST_W   = 2;

	localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
	localparam logic [OP_W-1:0] OP_POP  = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;
	localparam logic [ST_W-1:0] ST_BADPOS    = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} dp_cmd_t;

endpackage

// ===== rtl/core/bounded_stack_with_peek.sv =====
// An accepted request passes through capture, memory access and result load, in that order;
// the load waits while the output register holds a result not yet taken.
// The controller takes no new request until the result load is done.
// The output register lets a new request be taken while a result waits.
// Reset (arst_n, asynchronous, active low) empties the stack and sets capacity
// to 256; stack memory contents are not cleared.
`timescale 1ns / 1ps

module bounded_stack_with_peek #(
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic        [bstack_pkg::CAP_W-1:0]   cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic        [bstack_pkg::OP_W-1:0]    op,
	input  logic signed [bstack_pkg::DATA_W-1:0]  push_value,
	input  logic        [bstack_pkg::POS_W-1:0]   position,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [bstack_pkg::DATA_W-1:0]  read_value,
	output logic        [bstack_pkg::ST_W-1:0]    status,
	output logic                                  is_empty,
	output logic                                  is_full
);
	import bstack_pkg::*;

	dp_cmd_t cmd;

	bstack_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	bstack_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.op          (op),
		.push_value  (push_value),
		.position    (position),
		.read_value  (read_value),
		.status      (status),
		.is_empty    (is_empty),
		.is_full     (is_full)
	);

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while the previous one is still in progress");

	a_exec_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.exec)
		else $error("memory access did not follow an accepted request");

	a_load_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid || out_ready))
		else $error("result loaded over an untaken result");
`endif

endmodule

// ===== rtl/core/bstack_ctrl.sv =====
`timescale 1ns / 1ps

module bstack_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output bstack_pkg::dp_cmd_t cmd
);
	import bstack_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec  = 1'b1;
				state_nxt = S_RESP;
			end
			S_RESP: begin
				// The result waits here until the output register is free.
				if (!out_valid_q || out_ready) begin
					cmd.load  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/bstack_dp.sv =====
`timescale 1ns / 1ps

module bstack_dp #(
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  bstack_pkg::dp_cmd_t                   cmd,
	input  logic                                  cfg_wr_en,
	input  logic        [bstack_pkg::CAP_W-1:0]   cfg_wr_data,
	input  logic        [bstack_pkg::OP_W-1:0]    op,
	input  logic signed [bstack_pkg::DATA_W-1:0]  push_value,
	input  logic        [bstack_pkg::POS_W-1:0]   position,
	output logic signed [bstack_pkg::DATA_W-1:0]  read_value,
	output logic        [bstack_pkg::ST_W-1:0]    status,
	output logic                                  is_empty,
	output logic                                  is_full
);
	import bstack_pkg::*;

	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  count_q;

	logic [OP_W-1:0]   op_q;
	logic [DATA_W-1:0] push_value_q;
	logic [POS_W-1:0]  position_q;

	logic [DATA_W-1:0] stack_mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic              use_rd_q;
	logic [ST_W-1:0]   res_status_q;

	logic [DATA_W-1:0] read_value_q;
	logic [ST_W-1:0]   status_q;
	logic              is_empty_q;
	logic              is_full_q;

	logic [CMP_W-1:0]  count_ext;
	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  peek_diff;
	logic [CMP_W-1:0]  pop_diff;
	logic              full;
	logic              peek_ok;

	logic              wr_en;
	logic              use_rd;
	logic              inc;
	logic              dec;
	logic [ADDR_W-1:0] mem_addr;
	logic [ST_W-1:0]   res_status;

	assign count_ext = CMP_W'(count_q);
	assign pos_ext   = CMP_W'(position_q);
	assign peek_diff = count_ext - pos_ext;
	assign pop_diff  = count_ext - CMP_W'(1);

	// Effective capacity is the smaller of the register and the store depth.
	assign full    = (count_ext >= CMP_W'(capacity_q)) || (count_ext >= CMP_W'(DEPTH));
	assign peek_ok = (position_q != '0) && (pos_ext <= count_ext);

	always_comb begin
		wr_en      = 1'b0;
		use_rd     = 1'b0;
		inc        = 1'b0;
		dec        = 1'b0;
		mem_addr   = count_q[ADDR_W-1:0];
		res_status = ST_OK;
		case (op_q)
			OP_PUSH: begin
				if (full) begin
					res_status = ST_OVERFLOW;
				end else begin
					wr_en = 1'b1;
					inc   = 1'b1;
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					res_status = ST_UNDERFLOW;
				end else begin
					use_rd   = 1'b1;
					dec      = 1'b1;
					mem_addr = pop_diff[ADDR_W-1:0];
				end
			end
			OP_PEEK: begin
				if (!peek_ok) begin
					res_status = ST_BADPOS;
				end else begin
					use_rd   = 1'b1;
					mem_addr = peek_diff[ADDR_W-1:0];
				end
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (dec) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q         <= op;
			push_value_q <= push_value;
			position_q   <= position;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			stack_mem_q[mem_addr] <= push_value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rd_data_q    <= stack_mem_q[mem_addr];
			use_rd_q     <= use_rd;
			res_status_q <= res_status;
		end
	end

	// Flags are taken from the count after the operation has been applied.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			read_value_q <= use_rd_q ? rd_data_q : '1;
			status_q     <= res_status_q;
			is_empty_q   <= (count_q == '0);
			is_full_q    <= full;
		end
	end

	assign read_value = read_value_q;
	assign status     = status_q;
	assign is_empty   = is_empty_q;
	assign is_full    = is_full_q;

endmodule
